[rtl/border_box_color_averager_assert.svh]
`ifndef BORDER_BOX_COLOR_AVERAGER_ASSERT_SVH
`define BORDER_BOX_COLOR_AVERAGER_ASSERT_SVH

// same-cycle implication, off while in reset
`define BBCA_ASSERT_IMP(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("bbca assertion failed");

// next-cycle implication, off while in reset
`define BBCA_ASSERT_NXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("bbca assertion failed");

// next-cycle implication, also checked through reset
`define BBCA_ASSERT_NXT_ANY(lbl, ck, pre, post) \
  lbl: assert property (@(posedge ck) (pre) |=> (post)) \
    else $error("bbca assertion failed");

`endif

[rtl/bbca_pkg.sv]
package bbca_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 144;
  localparam int BOX_EDGE     = 2;
  localparam int CHANNELS     = 3;

  localparam int BOX_COLS = FRAME_WIDTH / BOX_EDGE;
  localparam int BOX_ROWS = FRAME_HEIGHT / BOX_EDGE;
  localparam int BOX_AREA = BOX_EDGE * BOX_EDGE;
  localparam bit BOXES_OK = (BOX_COLS >= 2) && (BOX_ROWS >= 2);

  localparam int PIX_W = 8;
  localparam int POS_W = 9;
  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT);
  localparam int BOX_W = (BOX_EDGE > 1) ? $clog2(BOX_EDGE) : 1;

  localparam int BAND_DEPTH = (BOX_COLS > 1) ? BOX_COLS : 2;
  localparam int BAND_AW    = $clog2(BAND_DEPTH);

  localparam int SLOT_END = 2 * (BOX_COLS + BOX_ROWS) - 1;
  localparam int SLOT_W   = (SLOT_END > 1) ? $clog2(SLOT_END + 1) : 1;

  localparam int AREA_LOG  = $clog2(BOX_AREA);
  localparam int SUM_W     = PIX_W + AREA_LOG;
  localparam int DIV_SHIFT = SUM_W + AREA_LOG;
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + BOX_AREA - 1) / BOX_AREA;
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + MULT_W;

  localparam int ITEM_DEPTH = 4;
  localparam int ITEM_AW    = $clog2(ITEM_DEPTH);
  localparam int ITEM_CNT_W = $clog2(ITEM_DEPTH + 1);

  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BAND,
    KIND_LEFT,
    KIND_RIGHT
  } kind_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } rgb_sum_t;

  localparam int RGB_SUM_W = CHANNELS * SUM_W;

  typedef struct packed {
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic             dual;
    logic             fc_a;
    logic             fc_b;
  } slot_info_t;

  typedef struct packed {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [BAND_AW-1:0] band_idx;
    kind_t              kind;
    logic               seg_first;
    logic               seg_last;
    logic               row_first;
    logic               box_last;
    slot_info_t         slot;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] avg_red;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_blue;
    slot_info_t       slot;
  } box_res_t;

  // exact floor(x / BOX_AREA) for any x below 2**SUM_W
  function automatic logic [PIX_W-1:0] div_area(input logic [SUM_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(DIV_MULT);
    return p[DIV_SHIFT +: PIX_W];
  endfunction

endpackage

[rtl/bbca_ram.sv]
module bbca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bbca_front.sv]
module bbca_front import bbca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  logic [PIX_W-1:0] pixel_red,
  input  logic [PIX_W-1:0] pixel_green,
  input  logic [PIX_W-1:0] pixel_blue,
  input  logic             start_of_frame,
  output logic             enq,
  output item_t            item
);

  logic [COL_W-1:0] col, col_next, cur_col;
  logic [ROW_W-1:0] row, row_next, cur_row;
  logic [BOX_W-1:0] cx, cx_next, cur_cx;
  logic [BOX_W-1:0] ry, ry_next, cur_ry;
  logic [COL_W-1:0] bi, bi_next, cur_bi;
  logic [ROW_W-1:0] bj, bj_next, cur_bj;

  logic accept;
  logic in_box;
  logic is_top, is_bot, is_left, is_right;
  kind_t kind;
  logic [SLOT_W-1:0] s_bot, s_left, s_top, s_right, s_a, s_b;
  logic dual;

  assign accept = push && !full;

  always_comb begin
    cur_col = start_of_frame ? '0 : col;
    cur_row = start_of_frame ? '0 : row;
    cur_cx  = start_of_frame ? '0 : cx;
    cur_ry  = start_of_frame ? '0 : ry;
    cur_bi  = start_of_frame ? '0 : bi;
    cur_bj  = start_of_frame ? '0 : bj;

    col_next = col;
    row_next = row;
    cx_next  = cx;
    ry_next  = ry;
    bi_next  = bi;
    bj_next  = bj;
    if (accept) begin
      row_next = cur_row;
      ry_next  = cur_ry;
      bj_next  = cur_bj;
      if (cur_col == COL_W'(FRAME_WIDTH - 1)) begin
        col_next = '0;
        cx_next  = '0;
        bi_next  = '0;
        if (cur_row == ROW_W'(FRAME_HEIGHT - 1)) begin
          row_next = '0;
          ry_next  = '0;
          bj_next  = '0;
        end else begin
          row_next = cur_row + 1'b1;
          if (cur_ry == BOX_W'(BOX_EDGE - 1)) begin
            ry_next = '0;
            bj_next = cur_bj + 1'b1;
          end else begin
            ry_next = cur_ry + 1'b1;
          end
        end
      end else begin
        col_next = cur_col + 1'b1;
        if (cur_cx == BOX_W'(BOX_EDGE - 1)) begin
          cx_next = '0;
          bi_next = cur_bi + 1'b1;
        end else begin
          cx_next = cur_cx + 1'b1;
          bi_next = cur_bi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      cx  <= '0;
      ry  <= '0;
      bi  <= '0;
      bj  <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      cx  <= cx_next;
      ry  <= ry_next;
      bi  <= bi_next;
      bj  <= bj_next;
    end
  end

  // classify the pixel by its box
  always_comb begin
    in_box = ({1'b0, cur_bi} < (COL_W + 1)'(BOX_COLS))
          && ({1'b0, cur_bj} < (ROW_W + 1)'(BOX_ROWS));
    is_top   = (cur_bj == '0);
    is_bot   = (cur_bj == ROW_W'(BOX_ROWS - 1));
    is_left  = (cur_bi == '0);
    is_right = (cur_bi == COL_W'(BOX_COLS - 1));

    if (is_top || is_bot) begin
      kind = KIND_BAND;
    end else if (is_left) begin
      kind = KIND_LEFT;
    end else if (is_right) begin
      kind = KIND_RIGHT;
    end else begin
      kind = KIND_NONE;
    end

    s_bot   = SLOT_W'(BOX_COLS - 1) - SLOT_W'(cur_bi);
    s_left  = SLOT_W'(BOX_COLS + BOX_ROWS - 1) - SLOT_W'(cur_bj);
    s_top   = SLOT_W'(BOX_COLS + BOX_ROWS) + SLOT_W'(cur_bi);
    s_right = SLOT_W'(2 * BOX_COLS + BOX_ROWS) + SLOT_W'(cur_bj);

    // slots in ascending clockwise order, first two that apply
    if (is_bot) begin
      s_a  = s_bot;
      s_b  = is_left ? s_left : s_right;
      dual = is_left || is_right;
    end else if (is_left) begin
      s_a  = s_left;
      s_b  = s_top;
      dual = is_top;
    end else if (is_top) begin
      s_a  = s_top;
      s_b  = s_right;
      dual = is_right;
    end else begin
      s_a  = s_right;
      s_b  = s_right;
      dual = 1'b0;
    end

    enq = accept && BOXES_OK && in_box && (kind != KIND_NONE);

    item.red        = pixel_red;
    item.green      = pixel_green;
    item.blue       = pixel_blue;
    item.band_idx   = BAND_AW'(cur_bi);
    item.kind       = kind;
    item.seg_first  = (cur_cx == '0);
    item.seg_last   = (cur_cx == BOX_W'(BOX_EDGE - 1));
    item.row_first  = (cur_ry == '0);
    item.box_last   = (cur_cx == BOX_W'(BOX_EDGE - 1)) && (cur_ry == BOX_W'(BOX_EDGE - 1));
    item.slot.pos_a = POS_W'(s_a);
    item.slot.pos_b = POS_W'(s_b);
    item.slot.dual  = dual;
    item.slot.fc_a  = (s_a == SLOT_W'(SLOT_END));
    item.slot.fc_b  = (s_b == SLOT_W'(SLOT_END));
  end

endmodule

[rtl/bbca_item_queue.sv]
module bbca_item_queue import bbca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  valid,
  input  logic  pop,
  output item_t head
);

  item_t                 mem [ITEM_DEPTH];
  logic [ITEM_AW-1:0]    wr_ptr, rd_ptr;
  logic [ITEM_CNT_W-1:0] count;

  assign full  = (count == ITEM_CNT_W'(ITEM_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ITEM_CNT_W'(push) - ITEM_CNT_W'(pop);
    end
  end

endmodule

[rtl/bbca_back.sv]
module bbca_back import bbca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 q_pop,
  input  logic [OUT_CNT_W-1:0] res_count,
  output logic                 res_push,
  output box_res_t             res_data
);

  logic issue;
  logic [OUT_CNT_W:0] pending;

  rgb_sum_t seg, seg_next;

  logic               b_valid;
  rgb_sum_t           b_sum;
  kind_t              b_kind;
  logic               b_row_first;
  logic               b_box_last;
  logic [BAND_AW-1:0] b_idx;
  slot_info_t         b_slot;

  rgb_sum_t b_old, b_total;
  rgb_sum_t left_sum, right_sum;

  logic [RGB_SUM_W-1:0] ram_rdata;
  logic                 ram_re, ram_we;

  logic       c_valid;
  rgb_sum_t   c_total;
  slot_info_t c_slot;

  // results already on their way must still fit in the result queue
  assign pending = {1'b0, res_count} + (OUT_CNT_W + 1)'(b_valid && b_box_last)
                 + (OUT_CNT_W + 1)'(c_valid);
  assign issue   = q_valid && (pending < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign q_pop   = issue;

  // row segment of a box
  always_comb begin
    if (q_item.seg_first) begin
      seg_next.red   = SUM_W'(q_item.red);
      seg_next.green = SUM_W'(q_item.green);
      seg_next.blue  = SUM_W'(q_item.blue);
    end else begin
      seg_next.red   = seg.red + SUM_W'(q_item.red);
      seg_next.green = seg.green + SUM_W'(q_item.green);
      seg_next.blue  = seg.blue + SUM_W'(q_item.blue);
    end
  end

  assign ram_re = issue && q_item.seg_last && (q_item.kind == KIND_BAND);
  assign ram_we = b_valid && (b_kind == KIND_BAND);

  bbca_ram #(
    .WIDTH (RGB_SUM_W),
    .DEPTH (BAND_DEPTH)
  ) u_band_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_idx),
    .wdata (b_total),
    .re    (ram_re),
    .raddr (q_item.band_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (issue) begin
      seg <= seg_next;
    end
    if (issue && q_item.seg_last) begin
      b_sum       <= seg_next;
      b_kind      <= q_item.kind;
      b_row_first <= q_item.row_first;
      b_box_last  <= q_item.box_last;
      b_idx       <= q_item.band_idx;
      b_slot      <= q_item.slot;
    end
  end

  // fold the segment into the box sum
  always_comb begin
    case (b_kind)
      KIND_BAND: b_old = ram_rdata;
      KIND_LEFT: b_old = left_sum;
      default:   b_old = right_sum;
    endcase
    if (b_row_first) begin
      b_total = b_sum;
    end else begin
      b_total.red   = b_old.red + b_sum.red;
      b_total.green = b_old.green + b_sum.green;
      b_total.blue  = b_old.blue + b_sum.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && (b_kind == KIND_LEFT)) begin
      left_sum <= b_total;
    end
    if (b_valid && (b_kind == KIND_RIGHT)) begin
      right_sum <= b_total;
    end
    if (b_valid && b_box_last) begin
      c_total <= b_total;
      c_slot  <= b_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= issue && q_item.seg_last;
      c_valid <= b_valid && b_box_last;
    end
  end

  assign res_push           = c_valid;
  assign res_data.avg_red   = div_area(c_total.red);
  assign res_data.avg_green = div_area(c_total.green);
  assign res_data.avg_blue  = div_area(c_total.blue);
  assign res_data.slot      = c_slot;

endmodule

[rtl/bbca_result_queue.sv]
module bbca_result_queue import bbca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  box_res_t             push_data,
  output logic [OUT_CNT_W-1:0] count,
  input  logic                 pop,
  output logic                 empty,
  output logic [POS_W-1:0]     position_index,
  output logic [PIX_W-1:0]     avg_red,
  output logic [PIX_W-1:0]     avg_green,
  output logic [PIX_W-1:0]     avg_blue,
  output logic                 last_of_item,
  output logic                 frame_complete
);

  box_res_t          mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr, rd_ptr;
  logic              phase;
  box_res_t          head;
  logic              take, advance;

  assign head    = mem[rd_ptr];
  assign empty   = (count == '0);
  assign take    = pop && !empty;
  // a corner box leaves in two beats
  assign advance = take && (!head.slot.dual || phase);

  assign position_index = phase ? head.slot.pos_b : head.slot.pos_a;
  assign avg_red        = head.avg_red;
  assign avg_green      = head.avg_green;
  assign avg_blue       = head.avg_blue;
  assign last_of_item   = !head.slot.dual || phase;
  assign frame_complete = phase ? head.slot.fc_b : head.slot.fc_a;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      phase  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (advance) begin
        rd_ptr <= rd_ptr + 1'b1;
        phase  <= 1'b0;
      end else if (take) begin
        phase <= 1'b1;
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(advance);
    end
  end

endmodule

[rtl/border_box_color_averager.sv]
// channel  dir  handshake    fields
// pixel    in   push / full  pixel_red, pixel_green, pixel_blue, start_of_frame
// result   out  pop / empty  position_index, avg_red/green/blue, last_of_item, frame_complete
//
// one pixel accepted per cycle while full is low; a box result passes through the item
// queue, bbca_back's b and c registers and result queue; a corner box takes two result beats.
// full rises only when the four-entry item queue fills, which happens when results
// are not taken and the eight-entry result queue has no room left.
// reset clears position and queues; band sums are written before they are read, so
// no clearing pass runs.
module border_box_color_averager import bbca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_red,
  input  logic [PIX_W-1:0] pixel_green,
  input  logic [PIX_W-1:0] pixel_blue,
  input  logic             start_of_frame,
  output logic             empty,
  input  logic             pop,
  output logic [POS_W-1:0] position_index,
  output logic [PIX_W-1:0] avg_red,
  output logic [PIX_W-1:0] avg_green,
  output logic [PIX_W-1:0] avg_blue,
  output logic             last_of_item,
  output logic             frame_complete
);

  logic                 enq;
  item_t                enq_item;
  logic                 q_valid, q_pop;
  item_t                q_item;
  logic [OUT_CNT_W-1:0] res_count;
  logic                 res_push;
  box_res_t             res_data;

  bbca_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .pixel_red      (pixel_red),
    .pixel_green    (pixel_green),
    .pixel_blue     (pixel_blue),
    .start_of_frame (start_of_frame),
    .enq            (enq),
    .item           (enq_item)
  );

  bbca_item_queue u_item_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (enq),
    .push_item (enq_item),
    .full      (full),
    .valid     (q_valid),
    .pop       (q_pop),
    .head      (q_item)
  );

  bbca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  bbca_result_queue u_result_queue (
    .clk            (clk),
    .rst            (rst),
    .push           (res_push),
    .push_data      (res_data),
    .count          (res_count),
    .pop            (pop),
    .empty          (empty),
    .position_index (position_index),
    .avg_red        (avg_red),
    .avg_green      (avg_green),
    .avg_blue       (avg_blue),
    .last_of_item   (last_of_item),
    .frame_complete (frame_complete)
  );

endmodule

[rtl/bbca_checker.sv]
`include "border_box_color_averager_assert.svh"

module bbca_checker import bbca_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [POS_W-1:0] position_index,
  input logic [PIX_W-1:0] avg_red,
  input logic [PIX_W-1:0] avg_green,
  input logic [PIX_W-1:0] avg_blue,
  input logic             last_of_item,
  input logic             frame_complete
);

  logic [POS_W+3*PIX_W+1:0] beat_bits;

  assign beat_bits = {position_index, avg_red, avg_green, avg_blue, last_of_item,
                      frame_complete};

  // queues come out of reset empty
  `BBCA_ASSERT_NXT_ANY(a_reset_empty, clk, rst, empty && !full)

  // the end of a frame is always the last beat of its box
  `BBCA_ASSERT_IMP(a_fc_last, clk, rst, !empty && frame_complete, last_of_item)

  // second beat of a corner box follows at once
  `BBCA_ASSERT_NXT(a_corner_pair, clk, rst, !empty && pop && !last_of_item, !empty)

  // a waiting beat holds
  `BBCA_ASSERT_NXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(beat_bits))

endmodule

bind border_box_color_averager bbca_checker u_bbca_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .position_index (position_index),
  .avg_red        (avg_red),
  .avg_green      (avg_green),
  .avg_blue       (avg_blue),
  .last_of_item   (last_of_item),
  .frame_complete (frame_complete)
);

[tb/sv/tb_border_box_color_averager.sv]
`timescale 1ns / 1ps

module tb_border_box_color_averager import bbca_pkg::*; ();

  typedef struct {
    logic [POS_W-1:0] slot;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
    logic             frame_end;
  } box_mean_t;

  typedef enum {
    DRAIN_ALWAYS,
    DRAIN_HALF,
    DRAIN_SPARSE,
    DRAIN_PERIODIC
  } drain_mode_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             push;
  logic             full;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;
  logic             start_of_frame;
  logic             empty;
  logic             pop;
  logic [POS_W-1:0] position_index;
  logic [PIX_W-1:0] avg_red;
  logic [PIX_W-1:0] avg_green;
  logic [PIX_W-1:0] avg_blue;
  logic             last_of_item;
  logic             frame_complete;

  box_mean_t   pending_box_means [$];
  box_mean_t   head_box;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles = 0;

  // predictor state
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned band_sum [BOX_COLS][CHANNELS];
  int unsigned left_sum [CHANNELS];
  int unsigned right_sum [CHANNELS];

  border_box_color_averager dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .pixel_red      (pixel_red),
    .pixel_green    (pixel_green),
    .pixel_blue     (pixel_blue),
    .start_of_frame (start_of_frame),
    .empty          (empty),
    .pop            (pop),
    .position_index (position_index),
    .avg_red        (avg_red),
    .avg_green      (avg_green),
    .avg_blue       (avg_blue),
    .last_of_item   (last_of_item),
    .frame_complete (frame_complete)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void predict_box_means(input logic [PIX_W-1:0] r, g, b, input logic sof);
    int unsigned c, rw, i, j, n, k, ch;
    int unsigned px [CHANNELS];
    int unsigned slots [2];
    bit first, last;
    kind_t kind;
    box_mean_t m;
    px[0] = 32'(r);
    px[1] = 32'(g);
    px[2] = 32'(b);
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    rw = row_pos;
    col_pos++;
    if (col_pos >= FRAME_WIDTH) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= FRAME_HEIGHT) row_pos = 0;
    end
    if (!BOXES_OK) return;
    if (c >= BOX_COLS * BOX_EDGE || rw >= BOX_ROWS * BOX_EDGE) return;
    i = c / BOX_EDGE;
    j = rw / BOX_EDGE;
    first = (c % BOX_EDGE == 0) && (rw % BOX_EDGE == 0);
    last = (c % BOX_EDGE == BOX_EDGE - 1) && (rw % BOX_EDGE == BOX_EDGE - 1);
    if (j == 0 || j == BOX_ROWS - 1) kind = KIND_BAND;
    else if (i == 0) kind = KIND_LEFT;
    else if (i == BOX_COLS - 1) kind = KIND_RIGHT;
    else kind = KIND_NONE;
    if (kind == KIND_NONE) return;
    // px ends up holding the running box sums
    for (ch = 0; ch < CHANNELS; ch++) begin
      case (kind)
        KIND_BAND: begin
          if (!first) px[ch] += band_sum[i][ch];
          band_sum[i][ch] = px[ch];
        end
        KIND_LEFT: begin
          if (!first) px[ch] += left_sum[ch];
          left_sum[ch] = px[ch];
        end
        default: begin
          if (!first) px[ch] += right_sum[ch];
          right_sum[ch] = px[ch];
        end
      endcase
    end
    if (!last) return;
    n = 0;
    if (j == BOX_ROWS - 1 && n < 2) begin
      slots[n] = BOX_COLS - 1 - i;
      n++;
    end
    if (i == 0 && n < 2) begin
      slots[n] = BOX_COLS + BOX_ROWS - 1 - j;
      n++;
    end
    if (j == 0 && n < 2) begin
      slots[n] = BOX_COLS + BOX_ROWS + i;
      n++;
    end
    if (i == BOX_COLS - 1 && n < 2) begin
      slots[n] = 2 * BOX_COLS + BOX_ROWS + j;
      n++;
    end
    for (k = 0; k < n; k++) begin
      m.slot = POS_W'(slots[k]);
      m.red = PIX_W'(px[0] / BOX_AREA);
      m.green = PIX_W'(px[1] / BOX_AREA);
      m.blue = PIX_W'(px[2] / BOX_AREA);
      m.last = (k == n - 1);
      m.frame_end = (slots[k] == 2 * (BOX_COLS + BOX_ROWS) - 1);
      pending_box_means.push_back(m);
    end
  endfunction

  // one pixel beat; push stays high so the next beat can follow at once
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input logic sof);
    push <= 1'b1;
    pixel_red <= r;
    pixel_green <= g;
    pixel_blue <= b;
    start_of_frame <= sof;
    do @(posedge clk); while (full);
    predict_box_means(r, g, b, sof);
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 24);
    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
    push <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] frame_channel(input int unsigned col, row, ch);
    case ((col / BOX_EDGE + row / BOX_EDGE + ch) % 4)
      0: return '1;
      1: return '0;
      2: return PIX_W'($urandom_range(240, 255));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic test_directed_pixels();
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    push <= 1'b0;
    repeat (3) @(posedge clk);
    send_pixel(8'h01, 8'h80, 8'h7F, 1'b0);
    send_pixel(8'hFE, 8'h7F, 8'h80, 1'b0);
    // restart in the middle of a row, then twice in a row
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h0F, 8'hF0, 8'h3C, 1'b1);
    send_pixel(8'hC3, 8'h0F, 8'hF0, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_random_partial_frames();
    int unsigned sent, run_len, k;
    sent = 0;
    while (sent < 100) begin
      run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(20, 60) : $urandom_range(1, 19);
      if (run_len > 100 - sent) run_len = 100 - sent;
      for (k = 0; k < run_len; k++) begin
        send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                   PIX_W'($urandom_range(0, 255)),
                   (k == 0) && ($urandom_range(0, 7) != 0));
        pace_sender();
      end
      sent += run_len;
    end
  endtask

  task automatic test_receiver_holdoff();
    int unsigned k, col, row;
    for (k = 0; k < FRAME_WIDTH; k++) begin
      send_pixel(frame_channel(k, 0, 0), frame_channel(k, 0, 1), frame_channel(k, 0, 2),
                 k == 0);
      pace_sender();
    end
    // draining stops here and the next rows finish boxes, so results pile up while nothing is drained
    hold_cycles = 400;
    for (k = FRAME_WIDTH; k < 4 * FRAME_WIDTH; k++) begin
      col = k % FRAME_WIDTH;
      row = k / FRAME_WIDTH;
      send_pixel(frame_channel(col, row, 0), frame_channel(col, row, 1),
                 frame_channel(col, row, 2), 1'b0);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got, want);
    if (got !== want) begin
      report_mismatch($sformatf("slot %0d %s got %0h want %0h", head_box.slot, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_box_means.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, slot %0d", position_index));
      end else begin
        head_box = pending_box_means.pop_front();
        check_field("position_index", 32'(position_index), 32'(head_box.slot));
        check_field("avg_red", 32'(avg_red), 32'(head_box.red));
        check_field("avg_green", 32'(avg_green), 32'(head_box.green));
        check_field("avg_blue", 32'(avg_blue), 32'(head_box.blue));
        check_field("last_of_item", 32'(last_of_item), 32'(head_box.last));
        check_field("frame_complete", 32'(frame_complete), 32'(head_box.frame_end));
      end
    end
  end

  initial begin : drain_results
    drain_mode_t drain_mode;
    int unsigned phase_left;
    drain_mode = DRAIN_ALWAYS;
    phase_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          drain_mode = drain_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(8, 80);
        end
        phase_left--;
        case (drain_mode)
          DRAIN_ALWAYS: pop <= 1'b1;
          DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: pop <= ($urandom_range(0, 7) == 0);
          default: pop <= (phase_left % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    #25ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    pixel_red <= '0;
    pixel_green <= '0;
    pixel_blue <= '0;
    start_of_frame <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_pixels();
    test_random_partial_frames();
    test_receiver_holdoff();
    push <= 1'b0;
    while (pending_box_means.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[border_box_color_averager.f]
+incdir+rtl
rtl/bbca_pkg.sv
rtl/bbca_ram.sv
rtl/bbca_front.sv
rtl/bbca_item_queue.sv
rtl/bbca_back.sv
rtl/bbca_result_queue.sv
rtl/border_box_color_averager.sv
rtl/bbca_checker.sv
tb/sv/tb_border_box_color_averager.sv
